// File: src/tpsd_pkg.sv
// Shared types and constants for the TGA pixel stream decoder.
// No dependencies; all source files but tpsd_checker import this package.
package tpsd_pkg;

   localparam int ByteWidth  = 8;
   localparam int CountWidth = 31;
   localparam int PixelWidth = 24;

   localparam logic [6:0] LenMask = 7'b1111111;

   typedef enum logic {
      MODE_RAW24 = 1'b0,
      MODE_RLE32 = 1'b1
   } pixel_mode_type;

   typedef enum logic {
      CSR_PIXEL_MODE   = 1'b0,
      CSR_TOTAL_PIXELS = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                 valid;
      logic [ByteWidth-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [ByteWidth-1:0] blue;
      logic [ByteWidth-1:0] green;
      logic [ByteWidth-1:0] red;
      logic [ByteWidth-1:0] alpha;
      logic [ByteWidth-1:0] repeat_count;
      logic                 image_end;
      logic                 run_clipped;
   } pixel_type;

endpackage

// File: src/tpsd_input_reg.sv
// Input register stage of the TGA pixel stream decoder.
// Depends on tpsd_pkg.
module tpsd_input_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [tpsd_pkg::ByteWidth-1:0] req_data_byte,
   output logic                          req_stall,
   input  logic                          out_free,
   output tpsd_pkg::item_type            item,
   output logic                          advance
);
   import tpsd_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ByteWidth-1:0] byte_ff;

   assign advance   = valid_ff && out_free;
   assign req_stall = valid_ff && !out_free;

   always_comb begin
      if (!req_stall) begin
         valid_in = req_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         byte_ff <= req_data_byte;
      end
   end

   assign item.valid     = valid_ff;
   assign item.data_byte = byte_ff;

endmodule

// File: src/tpsd_decode.sv
// Configuration registers, packet state and pixel assembly logic.
// Depends on tpsd_pkg.
module tpsd_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  tpsd_pkg::csr_index_type        csr_index,
   input  logic [tpsd_pkg::CountWidth-1:0] csr_write_data,
   input  tpsd_pkg::item_type             item,
   input  logic                           advance,
   output logic                           has_result,
   output tpsd_pkg::pixel_type            result
);
   import tpsd_pkg::*;

   pixel_mode_type        mode_ff;
   logic [CountWidth-1:0] total_ff;

   logic                  expect_ff, expect_in;
   logic                  is_run_ff, is_run_in;
   logic [ByteWidth-1:0]  remaining_ff, remaining_in;
   logic [1:0]            pos_ff, pos_in;
   logic [PixelWidth-1:0] partial_ff, partial_in;
   logic [CountWidth-1:0] done_ff, done_in;
   logic                  clipped_ff, clipped_in;

   logic [CountWidth-1:0] eff_total;
   logic [CountWidth:0]   diff;
   logic [CountWidth-1:0] left;
   logic [ByteWidth-1:0]  hdr_count;
   logic [ByteWidth-1:0]  rem_dec;
   logic [ByteWidth-1:0]  pix_count;
   logic [CountWidth:0]   sum;
   logic                  is_end;
   logic [PixelWidth-1:0] shifted;
   logic [ByteWidth-1:0]  data;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RLE32;
         total_ff <= CountWidth'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PIXEL_MODE:   mode_ff  <= pixel_mode_type'(csr_write_data[0]);
            CSR_TOTAL_PIXELS: total_ff <= csr_write_data;
            default:          mode_ff  <= mode_ff;
         endcase
      end
   end

   assign data      = item.data_byte;
   assign eff_total = (total_ff == '0) ? CountWidth'(1) : total_ff;
   assign diff      = {1'b0, eff_total} - {1'b0, done_ff};
   assign left      = (eff_total > done_ff) ? diff[CountWidth-1:0] : CountWidth'(1);
   assign hdr_count = {1'b0, data[6:0] & LenMask} + ByteWidth'(1);
   assign shifted   = PixelWidth'(data) << {pos_ff, 3'b000};
   assign rem_dec   = (remaining_ff == '0) ? '0 : remaining_ff - ByteWidth'(1);
   assign pix_count = (mode_ff == MODE_RLE32 && is_run_ff) ? remaining_ff : ByteWidth'(1);
   assign sum       = {1'b0, done_ff} + {{(CountWidth-ByteWidth+1){1'b0}}, pix_count};
   assign is_end    = sum >= {1'b0, eff_total};

   always_comb begin
      expect_in    = expect_ff;
      is_run_in    = is_run_ff;
      remaining_in = remaining_ff;
      pos_in       = pos_ff;
      partial_in   = partial_ff;
      done_in      = done_ff;
      clipped_in   = clipped_ff;
      has_result   = 1'b0;

      result.blue         = partial_ff[7:0];
      result.green        = partial_ff[15:8];
      result.red          = data;
      result.alpha        = '0;
      result.repeat_count = pix_count;
      result.run_clipped  = 1'b0;
      result.image_end    = is_end;

      if (item.valid && advance) begin
         if (mode_ff == MODE_RAW24) begin
            if (pos_ff[1]) begin
               pos_in     = '0;
               partial_in = '0;
               has_result = 1'b1;
            end else begin
               partial_in = partial_ff | shifted;
               pos_in     = pos_ff + 2'd1;
            end
         end else if (expect_ff) begin
            if ({{(CountWidth-ByteWidth){1'b0}}, hdr_count} > left) begin
               remaining_in = left[ByteWidth-1:0];
               clipped_in   = 1'b1;
            end else begin
               remaining_in = hdr_count;
               clipped_in   = 1'b0;
            end
            is_run_in  = data[7];
            expect_in  = 1'b0;
            pos_in     = '0;
            partial_in = '0;
         end else if (pos_ff != 2'd3) begin
            partial_in = partial_ff | shifted;
            pos_in     = pos_ff + 2'd1;
         end else begin
            result.red   = partial_ff[23:16];
            result.alpha = data;
            pos_in       = '0;
            partial_in   = '0;
            has_result   = 1'b1;
            if (is_run_ff) begin
               result.run_clipped = clipped_ff;
               remaining_in       = '0;
            end else begin
               remaining_in       = rem_dec;
               result.run_clipped = clipped_ff && (rem_dec == '0);
            end
            if (remaining_in == '0) begin
               expect_in  = 1'b1;
               clipped_in = 1'b0;
            end
         end

         if (has_result) begin
            if (is_end) begin
               done_in      = '0;
               remaining_in = '0;
               clipped_in   = 1'b0;
               expect_in    = 1'b1;
            end else begin
               done_in = sum[CountWidth-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff    <= 1'b1;
         is_run_ff    <= 1'b0;
         remaining_ff <= '0;
         pos_ff       <= '0;
         partial_ff   <= '0;
         done_ff      <= '0;
         clipped_ff   <= 1'b0;
      end else begin
         expect_ff    <= expect_in;
         is_run_ff    <= is_run_in;
         remaining_ff <= remaining_in;
         pos_ff       <= pos_in;
         partial_ff   <= partial_in;
         done_ff      <= done_in;
         clipped_ff   <= clipped_in;
      end
   end

endmodule

// File: src/tpsd_output_reg.sv
// Result register stage of the TGA pixel stream decoder.
// Depends on tpsd_pkg.
module tpsd_output_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  tpsd_pkg::pixel_type            result,
   output logic                           out_free,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tpsd_pkg::pixel_type            rsp_pixel
);
   import tpsd_pkg::*;

   logic      valid_ff, valid_in;
   pixel_type pixel_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_free) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_pixel = pixel_ff;

endmodule

// File: src/tga_pixel_stream_decoder_core.sv
// Top level of the TGA pixel stream decoder.
// Depends on tpsd_pkg, tpsd_input_reg, tpsd_decode and tpsd_output_reg.
//
// Takes one payload byte per cycle and emits decoded pixels with a repeat
// count; the consumer expands runs. A byte is captured in the input register,
// decoded against the packet state once the result register is free, and a
// finished pixel lands in the result register. One byte is accepted every
// cycle as long as the result register is free or being drained; header
// bytes and partial pixel bytes produce no result. Configuration must be
// written by the user only while the block is idle, which it does not check.
module tga_pixel_stream_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [30:0] csr_write_data,
   input  logic        req_valid,
   input  logic [7:0]  req_data_byte,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_alpha,
   output logic [7:0]  rsp_repeat_count,
   output logic        rsp_image_end,
   output logic        rsp_run_clipped
);
   import tpsd_pkg::*;

   item_type  item;
   pixel_type result;
   pixel_type rsp_pixel;
   logic      advance;
   logic      out_free;
   logic      has_result;

   tpsd_input_reg u_input_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_data_byte (req_data_byte),
      .req_stall     (req_stall),
      .out_free      (out_free),
      .item          (item),
      .advance       (advance)
   );

   tpsd_decode u_decode (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index_type'(csr_index)),
      .csr_write_data   (csr_write_data),
      .item             (item),
      .advance          (advance),
      .has_result       (has_result),
      .result           (result)
   );

   tpsd_output_reg u_output_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (has_result),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_pixel (rsp_pixel)
   );

   assign rsp_blue         = rsp_pixel.blue;
   assign rsp_green        = rsp_pixel.green;
   assign rsp_red          = rsp_pixel.red;
   assign rsp_alpha        = rsp_pixel.alpha;
   assign rsp_repeat_count = rsp_pixel.repeat_count;
   assign rsp_image_end    = rsp_pixel.image_end;
   assign rsp_run_clipped  = rsp_pixel.run_clipped;

endmodule

// File: src/tpsd_checker.sv
// Port-level checks for the TGA pixel stream decoder, bound to the top level.
// Depends on tga_pixel_stream_decoder_core.
module tpsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_blue,
   input logic [7:0] rsp_green,
   input logic [7:0] rsp_red,
   input logic [7:0] rsp_alpha,
   input logic [7:0] rsp_repeat_count,
   input logic       rsp_image_end,
   input logic       rsp_run_clipped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_blue) && $stable(rsp_green)
         && $stable(rsp_red) && $stable(rsp_alpha) && $stable(rsp_repeat_count)
         && $stable(rsp_image_end) && $stable(rsp_run_clipped))
      else $error("result item changed while stalled");

   a_no_stall_when_empty: assert property (@(posedge clock)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result register");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_repeat_count != 8'd0 && rsp_repeat_count <= 8'd128)
      else $error("repeat count out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind tga_pixel_stream_decoder_core tpsd_checker u_tpsd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_blue         (rsp_blue),
   .rsp_green        (rsp_green),
   .rsp_red          (rsp_red),
   .rsp_alpha        (rsp_alpha),
   .rsp_repeat_count (rsp_repeat_count),
   .rsp_image_end    (rsp_image_end),
   .rsp_run_clipped  (rsp_run_clipped)
);

// File: dv/tpsd_pixel_checker.sv
// Checker for the TGA pixel stream decoder: watches the byte, pixel and register ports,
// predicts every decoded pixel and compares it with what the block emits.
// Depends on tpsd_pkg for the mode, register index and pixel types.
module tpsd_pixel_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [30:0] csr_write_data,
   input  logic        req_valid,
   input  logic [7:0]  req_data_byte,
   input  logic        req_stall,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_blue,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_alpha,
   input  logic [7:0]  rsp_repeat_count,
   input  logic        rsp_image_end,
   input  logic        rsp_run_clipped,
   output int          fail_count,
   output int          pending_count,
   output logic        between_images
);
   timeunit 1ns;
   timeprecision 1ps;

   import tpsd_pkg::*;

   pixel_mode_type cfg_mode;
   logic [30:0]    cfg_total;
   logic           awaiting_header;
   logic           run_packet;
   logic           packet_trimmed;
   logic [7:0]     pixels_in_packet;
   logic [1:0]     byte_slot;
   logic [23:0]    pixel_acc;
   logic [30:0]    pixels_emitted;
   pixel_type      expected_pixels[$];

   function automatic logic [31:0] image_size();
      return (cfg_total == '0) ? 32'd1 : {1'b0, cfg_total};
   endfunction

   task automatic emit_pixel(input logic [7:0] blue, input logic [7:0] green,
                             input logic [7:0] red, input logic [7:0] alpha,
                             input logic [7:0] count, input logic clip);
      pixel_type   px;
      logic [31:0] reached;
      reached         = {1'b0, pixels_emitted} + {24'b0, count};
      px.blue         = blue;
      px.green        = green;
      px.red          = red;
      px.alpha        = alpha;
      px.repeat_count = count;
      px.image_end    = (reached >= image_size());
      px.run_clipped  = clip;
      if (px.image_end) begin
         pixels_emitted   = '0;
         pixels_in_packet = '0;
         packet_trimmed   = 1'b0;
         awaiting_header  = 1'b1;
      end else begin
         pixels_emitted = reached[30:0];
      end
      expected_pixels = {expected_pixels, px};
   endtask

   task automatic decode_byte(input logic [7:0] data);
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  count;
      logic [31:0] span;
      logic [31:0] left;
      logic        clip;
      blue  = pixel_acc[7:0];
      green = pixel_acc[15:8];
      red   = pixel_acc[23:16];
      if (cfg_mode == MODE_RAW24) begin
         if (byte_slot >= 2'd2) begin
            byte_slot = '0;
            pixel_acc = '0;
            emit_pixel(blue, green, data, 8'd0, 8'd1, 1'b0);
         end else begin
            pixel_acc = pixel_acc | (24'(data) << (8 * byte_slot));
            byte_slot++;
         end
      end else if (awaiting_header) begin
         span = 32'(data[6:0]) + 32'd1;
         left = (image_size() > {1'b0, pixels_emitted}) ?
                image_size() - {1'b0, pixels_emitted} : 32'd1;
         packet_trimmed = (span > left);
         if (packet_trimmed) span = left;
         run_packet       = data[7];
         pixels_in_packet = span[7:0];
         awaiting_header  = 1'b0;
         byte_slot        = '0;
         pixel_acc        = '0;
      end else if (byte_slot < 2'd3) begin
         pixel_acc = pixel_acc | (24'(data) << (8 * byte_slot));
         byte_slot++;
      end else begin
         byte_slot = '0;
         pixel_acc = '0;
         if (run_packet) begin
            count            = pixels_in_packet;
            clip             = packet_trimmed;
            pixels_in_packet = '0;
         end else begin
            count = 8'd1;
            if (pixels_in_packet != '0) pixels_in_packet--;
            clip = packet_trimmed && (pixels_in_packet == '0);
         end
         if (pixels_in_packet == '0) begin
            awaiting_header = 1'b1;
            packet_trimmed  = 1'b0;
         end
         emit_pixel(blue, green, red, data, count, clip);
      end
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_pixel();
      pixel_type want;
      if (expected_pixels.size() == 0) begin
         $display("%0t: pixel with nothing expected, expected none, got b %0d g %0d r %0d a %0d x%0d",
                  $time, rsp_blue, rsp_green, rsp_red, rsp_alpha, rsp_repeat_count);
         fail_count++;
      end else begin
         want = expected_pixels.pop_front();
         check_field("blue", want.blue, rsp_blue);
         check_field("green", want.green, rsp_green);
         check_field("red", want.red, rsp_red);
         check_field("alpha", want.alpha, rsp_alpha);
         check_field("repeat_count", want.repeat_count, rsp_repeat_count);
         check_field("image_end", 8'(want.image_end), 8'(rsp_image_end));
         check_field("run_clipped", 8'(want.run_clipped), 8'(rsp_run_clipped));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_mode         = MODE_RLE32;
         cfg_total        = 31'd1;
         awaiting_header  = 1'b1;
         run_packet       = 1'b0;
         packet_trimmed   = 1'b0;
         pixels_in_packet = '0;
         byte_slot        = '0;
         pixel_acc        = '0;
         pixels_emitted   = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_pixel();
         if (csr_write_enable) begin
            if (csr_index == CSR_PIXEL_MODE) cfg_mode = pixel_mode_type'(csr_write_data[0]);
            else cfg_total = csr_write_data;
         end
         if (req_valid && !req_stall) decode_byte(req_data_byte);
      end
      pending_count  = expected_pixels.size();
      between_images = awaiting_header && (pixels_emitted == '0) && (byte_slot == '0);
   end

endmodule

// File: dv/tga_pixel_stream_decoder_core_test.sv
// Testbench top for the TGA pixel stream decoder: clock, reset, byte stream and
// register writes, random stalls on the pixel side, and the final verdict.
// Depends on tpsd_pkg, tpsd_pixel_checker and the decoder RTL.
module tga_pixel_stream_decoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tpsd_pkg::*;

   localparam int ItemTarget    = 1900;
   localparam int HoldOffCycles = 300;
   localparam int CycleLimit    = 400000;
   localparam int DrainCycles   = 4;
   localparam int SettleCycles  = 10;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic        csr_index;
   logic [30:0] csr_write_data;
   logic        req_valid;
   logic [7:0]  req_data_byte;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_alpha;
   logic [7:0]  rsp_repeat_count;
   logic        rsp_image_end;
   logic        rsp_run_clipped;

   int     fail_count;
   int     pending_count;
   logic   between_images;
   bit     calm;
   bit     stall_burst_req;
   int     bytes_sent;
   int     cycle_count;
   longint pixels_to_go;

   always #5 clock = ~clock;

   tga_pixel_stream_decoder_core u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_data_byte    (req_data_byte),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_blue         (rsp_blue),
      .rsp_green        (rsp_green),
      .rsp_red          (rsp_red),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_end    (rsp_image_end),
      .rsp_run_clipped  (rsp_run_clipped)
   );

   tpsd_pixel_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_data_byte    (req_data_byte),
      .req_stall        (req_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_blue         (rsp_blue),
      .rsp_green        (rsp_green),
      .rsp_red          (rsp_red),
      .rsp_alpha        (rsp_alpha),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_end    (rsp_image_end),
      .rsp_run_clipped  (rsp_run_clipped),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .between_images   (between_images)
   );

   task automatic send_byte(input logic [7:0] value);
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_bytes(input int count);
      repeat (count) send_byte(8'($urandom_range(255)));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic configure(input pixel_mode_type mode, input logic [30:0] total);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_PIXEL_MODE;
      csr_write_data   <= 31'(mode);
      @(negedge clock);
      csr_index        <= CSR_TOTAL_PIXELS;
      csr_write_data   <= total;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_rle_packet();
      logic   is_run;
      int     pick;
      int     span;
      longint taken;
      is_run = 1'($urandom_range(1));
      pick   = is_run ? $urandom_range(9) : $urandom_range(19);
      span   = (pick == 0) ? 128 : (pick == 1) ? $urandom_range(1, 128) : $urandom_range(1, 6);
      taken  = (span > pixels_to_go) ? pixels_to_go : span;
      send_byte({is_run, 7'(span - 1)});
      send_random_bytes(is_run ? 4 : 4 * int'(taken));
      pixels_to_go -= taken;
   endtask

   task automatic send_rle_image(input int max_packets);
      int packets;
      packets = 0;
      while (pixels_to_go > 0 && packets < max_packets) begin
         send_rle_packet();
         packets++;
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_burst_req) begin
            stall_burst_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(negedge clock);
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 9);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int             phase;
      int             pick;
      int             images;
      pixel_mode_type mode;
      logic [30:0]    total;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_PIXEL_MODE;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_data_byte    = '0;
      calm             = 1'b0;
      stall_burst_req  = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // long run clamped to a short image, one literal pixel, clamped literal packet
      configure(MODE_RLE32, 31'd4);
      repeat (5) send_byte(8'hFF);
      repeat (5) send_byte(8'h00);
      send_byte(8'h7F);
      send_random_bytes(12);
      // zero total behaves as one pixel
      configure(MODE_RAW24, 31'd0);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(8'hFE);

      phase = 0;
      while (bytes_sent < ItemTarget) begin
         calm = (phase >= 6 && phase < 10);
         pick = $urandom_range(19);
         mode = ($urandom_range(99) < 70) ? MODE_RLE32 : MODE_RAW24;
         if (pick == 0) total = 31'd0;
         else if (pick == 1) total = 31'h4000_0000;
         else if (pick == 2) total = 31'h7FFF_FFFF;
         else if (pick < 6) total = 31'd1;
         else if (pick < 16) total = 31'($urandom_range(2, 24));
         else total = 31'($urandom_range(25, 300));
         if (phase == 2) begin
            mode  = MODE_RLE32;
            total = 31'd64;
         end
         wait_idle();
         // realign to an image boundary most of the time, keep mid-image state otherwise
         if (!between_images && (phase == 2 || $urandom_range(3) != 0)) begin
            configure(MODE_RLE32, 31'd1);
            while (!between_images) send_byte(8'hFF);
         end
         configure(mode, total);
         if (phase == 2) stall_burst_req = 1'b1;
         if (mode == MODE_RLE32) begin
            images = (phase == 2) ? 6 : $urandom_range(1, 3);
            repeat (images) begin
               pixels_to_go = (total == '0) ? 1 : longint'(total);
               if (total > 31'd400) send_rle_image($urandom_range(3, 12));
               else if ($urandom_range(9) == 0) send_rle_image($urandom_range(1, 3));
               else send_rle_image(1000);
            end
         end else begin
            send_random_bytes(3 * $urandom_range(1, 40) +
                              (($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0));
         end
         if ($urandom_range(9) == 0) send_random_bytes($urandom_range(1, 6));
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// File: tga_pixel_stream_decoder_core.f
src/tpsd_pkg.sv
src/tpsd_input_reg.sv
src/tpsd_decode.sv
src/tpsd_output_reg.sv
src/tga_pixel_stream_decoder_core.sv
src/tpsd_checker.sv
dv/tpsd_pixel_checker.sv
dv/tga_pixel_stream_decoder_core_test.sv
